// ===== sv/pcap_pkg.sv =====
// Shared types, widths and codes for the PCA projection engine.
// Used by every module of the block except pcap_ram; depends on nothing.
package pcap_pkg;

	// Sizing of the block.
	localparam int WINDOW_MAX     = 256;
	localparam int COMPONENTS_MAX = 8;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_BITS      = 16;
	localparam int ACC_BITS       = 40;
	localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;

	// Derived index and count widths.
	localparam int POS_W       = $clog2(WINDOW_MAX);
	localparam int COMP_W      = (COMPONENTS_MAX > 1) ? $clog2(COMPONENTS_MAX) : 1;
	localparam int LEN_EFF_W   = $clog2(WINDOW_MAX + 1);
	localparam int NCOMP_EFF_W = $clog2(COMPONENTS_MAX + 1);

	// Fixed port widths.
	localparam int CMD_BITS      = 1;
	localparam int SIDX_BITS     = 8;
	localparam int CIDX_BITS     = 3;
	localparam int LEN_BITS      = 9;
	localparam int NCOMP_BITS    = 4;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 9;

	// Command codes.
	localparam logic [CMD_BITS-1:0] CMD_LOAD   = 1'b0;
	localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_LENGTH     = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_COMPONENTS = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [LEN_BITS-1:0]   LEN_RESET   = 9'd256;
	localparam logic [NCOMP_BITS-1:0] NCOMP_RESET = 4'd8;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [ACC_BITS-1:0]    acc_t;
	typedef coef_t [COMPONENTS_MAX-1:0]    coef_row_t;
	typedef acc_t  [COMPONENTS_MAX-1:0]    acc_row_t;

	// Single-lane write into the coefficient store.
	typedef struct packed {
		logic              en;
		logic [POS_W-1:0]  pos;
		logic [COMP_W-1:0] comp;
		coef_t             data;
	} coef_wr_t;

	// A sample request entering the MAC pipeline.
	typedef struct packed {
		logic    valid;
		logic    last;
		sample_t sample;
	} sample_req_t;

	// Completed window handed from the MAC array to the result queue.
	typedef struct packed {
		logic     done;
		acc_row_t sums;
	} win_result_t;

endpackage

// ===== sv/pcap_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read with a read enable; no package dependency.
module pcap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the output holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/pcap_coef_store.sv =====
// Coefficient store: one RAM per component, addressed by window position.
// Depends on pcap_pkg and pcap_ram.
module pcap_coef_store
	import pcap_pkg::*;
(
	input  logic             clk,
	input  coef_wr_t         wr,
	input  logic             rd_en,
	input  logic [POS_W-1:0] rd_pos,
	output coef_row_t        row
);

	// A whole row is read per sample; a load writes only its own lane.
	for (genvar k = 0; k < COMPONENTS_MAX; k++) begin : g_lane
		logic lane_we;

		assign lane_we = wr.en && (wr.comp == COMP_W'(k));

		pcap_ram #(
			.WIDTH(COEF_BITS),
			.DEPTH(WINDOW_MAX)
		) u_ram (
			.clk  (clk),
			.we   (lane_we),
			.waddr(wr.pos),
			.wdata(wr.data),
			.re   (rd_en),
			.raddr(rd_pos),
			.rdata(row[k])
		);
	end

endmodule

// ===== sv/pcap_mac.sv =====
// Multiply-accumulate lanes: products of one sample with a coefficient row,
// added into per-component accumulators. Depends on pcap_pkg.
module pcap_mac
	import pcap_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  sample_req_t            req,
	input  coef_row_t              row,
	input  logic [NCOMP_EFF_W-1:0] eff_comps,
	output win_result_t            result
);

	logic     valid_s1;
	logic     last_s1;
	sample_t  sample_s1;
	logic     valid_s2;
	logic     last_s2;
	acc_row_t prod_s2;
	acc_row_t acc_q;

	logic signed [PROD_BITS-1:0] prod [COMPONENTS_MAX];
	logic [COMPONENTS_MAX-1:0]   active;
	acc_row_t                    sums;

	// Control of the two pipeline stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
			last_s1  <= req.last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
		end
	end

	// Lane products; the row arrives from the store in the cycle after the request.
	always_comb begin
		for (int k = 0; k < COMPONENTS_MAX; k++) begin
			active[k] = k < int'(eff_comps);
			prod[k]   = $signed(sample_s1) * $signed(row[k]);
		end
	end

	// Payload registers; inactive lanes carry zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= req.sample;
			for (int k = 0; k < COMPONENTS_MAX; k++) begin
				prod_s2[k] <= active[k] ? ACC_BITS'(prod[k]) : '0;
			end
		end
	end

	// Running sums, wrapping at the accumulator width.
	always_comb begin
		for (int k = 0; k < COMPONENTS_MAX; k++) begin
			sums[k] = acc_q[k] + prod_s2[k];
		end
	end

	// Accumulators clear once a window's totals have been handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && valid_s2) begin
			acc_q <= last_s2 ? '0 : sums;
		end
	end

	assign result.done = valid_s2 && last_s2;
	assign result.sums = sums;

endmodule

// ===== sv/pcap_result_queue.sv =====
// Result bank: holds one window's totals and sends them one per request.
// Depends on pcap_pkg.
module pcap_result_queue
	import pcap_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  win_result_t            result,
	input  logic [NCOMP_EFF_W-1:0] eff_comps,
	output logic                   busy,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CIDX_BITS-1:0]   component_index,
	output acc_t                   component_value,
	output logic                   last_component
);

	acc_row_t          bank_q;
	logic              busy_q;
	logic [COMP_W-1:0] idx_q;
	logic              load;
	logic              take;
	logic              is_last;

	assign load    = result.done && !busy_q;
	assign take    = busy_q && out_ready;
	assign is_last = idx_q == COMP_W'(eff_comps - 1'b1);

	// Totals are captured only into an empty bank.
	always_ff @(posedge clk) begin
		if (load) begin
			bank_q <= result.sums;
		end
	end

	// Emission counter over the active components.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (is_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign busy            = busy_q;
	assign out_valid       = busy_q;
	assign component_index = CIDX_BITS'(idx_q);
	assign component_value = bank_q[idx_q];
	assign last_component  = is_last;

endmodule

// ===== sv/pca_projection_engine_core.sv =====
// Top level of the PCA projection engine.
// Depends on pcap_pkg, pcap_coef_store, pcap_mac and pcap_result_queue.
//
// The block takes one request per cycle while in_ready is high. A load
// request writes one Q1.15 coefficient into the per-component store RAMs; a
// sample request reads the coefficient row for the current window position;
// the product of sample and coefficient is registered in stage two and then
// added into each active component's 40-bit accumulator. The last sample of a
// window puts its totals into a result bank once it leaves stage two, and the
// bank sends active_components results, one per cycle while out_ready is
// high, the final one flagged. The next window accumulates while the bank
// drains; input is held off only when a further window ends before the bank
// has emptied, since the single result bank takes no new totals until its
// last result has been sent. The coefficient store has no reset and must be
// loaded before use; there is no clearing pass.
module pca_projection_engine_core
	import pcap_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_BITS-1:0]      cmd,
	input  logic [SIDX_BITS-1:0]     coef_sample_index,
	input  logic [CIDX_BITS-1:0]     coef_component_index,
	input  logic signed [15:0]       value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [CIDX_BITS-1:0]     component_index,
	output logic signed [ACC_BITS-1:0] component_value,
	output logic                     last_component,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	logic [LEN_BITS-1:0]    len_q;
	logic [NCOMP_BITS-1:0]  ncomp_q;
	logic [POS_W-1:0]       pos_q;
	logic [LEN_EFF_W-1:0]   eff_len;
	logic [NCOMP_EFF_W-1:0] eff_comps;
	logic                   adv;
	logic                   accept;
	logic                   is_sample;
	logic                   win_last;
	logic                   busy;
	coef_wr_t               wr;
	sample_req_t            req;
	coef_row_t              row;
	win_result_t            result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_RESET;
			ncomp_q <= NCOMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_LENGTH:     len_q   <= LEN_BITS'(cfg_wdata);
				REG_ACTIVE_COMPONENTS: ncomp_q <= cfg_wdata[NCOMP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Register values clamped into their working ranges.
	always_comb begin
		if (len_q == '0) begin
			eff_len = LEN_EFF_W'(1);
		end else if (int'(len_q) > WINDOW_MAX) begin
			eff_len = LEN_EFF_W'(WINDOW_MAX);
		end else begin
			eff_len = LEN_EFF_W'(len_q);
		end
		if (ncomp_q == '0) begin
			eff_comps = NCOMP_EFF_W'(1);
		end else if (int'(ncomp_q) > COMPONENTS_MAX) begin
			eff_comps = NCOMP_EFF_W'(COMPONENTS_MAX);
		end else begin
			eff_comps = NCOMP_EFF_W'(ncomp_q);
		end
	end

	// The pipeline halts only when a finished window meets a full bank.
	assign adv       = !(result.done && busy);
	assign in_ready  = adv;
	assign accept    = in_valid && in_ready;
	assign is_sample = cmd == CMD_SAMPLE;
	assign win_last  = ({1'b0, pos_q} + 1'b1) >= eff_len;

	// Coefficient loads outside the store are dropped.
	assign wr.en   = accept && (cmd == CMD_LOAD)
		&& (int'(coef_sample_index) < WINDOW_MAX)
		&& (int'(coef_component_index) < COMPONENTS_MAX);
	assign wr.pos  = POS_W'(coef_sample_index);
	assign wr.comp = COMP_W'(coef_component_index);
	assign wr.data = coef_t'(value);

	assign req.valid  = accept && is_sample;
	assign req.last   = win_last;
	assign req.sample = sample_t'(value);

	// Window position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (req.valid) begin
			pos_q <= win_last ? '0 : pos_q + 1'b1;
		end
	end

	pcap_coef_store u_store (
		.clk   (clk),
		.wr    (wr),
		.rd_en (req.valid),
		.rd_pos(pos_q),
		.row   (row)
	);

	pcap_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.req      (req),
		.row      (row),
		.eff_comps(eff_comps),
		.result   (result)
	);

	pcap_result_queue u_queue (
		.clk            (clk),
		.arst_n         (arst_n),
		.result         (result),
		.eff_comps      (eff_comps),
		.busy           (busy),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.component_index(component_index),
		.component_value(component_value),
		.last_component (last_component)
	);

endmodule

// ===== sv/pcap_checker.sv =====
// Port-level checks for the PCA projection engine, bound to its top level.
// Depends on pcap_pkg and pca_projection_engine_core.
module pcap_checker
	import pcap_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [CIDX_BITS-1:0]     component_index,
	input logic signed [ACC_BITS-1:0] component_value,
	input logic                     last_component
);

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(component_index)
			&& $stable(component_value) && $stable(last_component))
		else $error("stalled result changed");

	// Within a window the component numbers count up by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_component |=>
			out_valid && (component_index == $past(component_index) + 1'b1))
		else $error("component sequence broken");

	// After a window's final result the next one shown starts at component zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_component |=>
			!out_valid || (component_index == '0))
		else $error("new window does not start at component zero");

	// Input is held off only while results are waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

endmodule

bind pca_projection_engine_core pcap_checker u_checker (.*);
